// ===== hdl/rgb2yuv_pkg.sv =====
// Shared types, constants and the sample scaling function of the RGB to YCbCr 4:2:0 converter.
// Depends on nothing; front end, queue, back end, top and testbench use its scoped names.

package rgb2yuv_pkg;

  // Sizes of the config registers and port, the largest frame dimension and the queue depth.
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 4;
  localparam int MAX_DIM     = 4096;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Reset value of both frame size registers.
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

  // Smallest frame dimension that the position tracking honors.
  localparam int MIN_DIM = 2;

  // Width of the signed multiply-add sums.
  localparam int SUM_W = 18;
  typedef logic signed [SUM_W-1:0] sum_t;

  // BT.601 studio range coefficients, scaled by 256.
  localparam sum_t Y_R  = sum_t'(66);
  localparam sum_t Y_G  = sum_t'(129);
  localparam sum_t Y_B  = sum_t'(25);
  localparam sum_t CB_R = sum_t'(-38);
  localparam sum_t CB_G = sum_t'(-74);
  localparam sum_t CB_B = sum_t'(112);
  localparam sum_t CR_R = sum_t'(112);
  localparam sum_t CR_G = sum_t'(-94);
  localparam sum_t CR_B = sum_t'(-18);

  localparam sum_t ROUND_HALF = sum_t'(128);
  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  // One pixel as it travels from the front end to the arithmetic pipeline.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       chroma_valid;
    logic       chroma_is_cr;
    logic       frame_end;
  } pix_t;

  // Round, divide by 256 (floor), add the offset and keep eight bits.
  function automatic logic [7:0] scale_sample(sum_t s, logic [7:0] offset);
    sum_t t;
    t = s + ROUND_HALF;
    return t[15:8] + offset;
  endfunction

endpackage

// ===== hdl/rgb2yuv_front.sv =====
// Front end: configuration registers, raster position tracking and pixel classification.
// Depends on rgb2yuv_pkg for the config indexes, reset values and the pixel struct.

module rgb2yuv_front #(
  parameter int MaxDimension = rgb2yuv_pkg::MAX_DIM
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             pix_take_i,
  input  logic [7:0]                       red_i,
  input  logic [7:0]                       green_i,
  input  logic [7:0]                       blue_i,
  output rgb2yuv_pkg::pix_t                pix_o
);

  localparam int CntW  = (MaxDimension > 2) ? $clog2(MaxDimension) : 1;
  localparam int DimW  = $clog2(MaxDimension + 1);
  localparam int SizeW = (DimW > rgb2yuv_pkg::CFG_W) ? DimW : rgb2yuv_pkg::CFG_W;

  logic [rgb2yuv_pkg::CFG_W-1:0] width_q, height_q;
  logic [CntW-1:0]               col_q, col_d, row_q, row_d;
  logic [SizeW-1:0]              eff_w, eff_h;
  logic                          last_col, last_row;

  // Configuration writes; the port is always ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgb2yuv_pkg::SIZE_RESET;
      height_q <= rgb2yuv_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rgb2yuv_pkg::REG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == rgb2yuv_pkg::REG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Saturate the programmed sizes into the supported range.
  always_comb begin
    eff_w = SizeW'(width_q);
    if (width_q < rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MIN_DIM)) begin
      eff_w = SizeW'(rgb2yuv_pkg::MIN_DIM);
    end else if (SizeW'(width_q) > SizeW'(MaxDimension)) begin
      eff_w = SizeW'(MaxDimension);
    end
    eff_h = SizeW'(height_q);
    if (height_q < rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MIN_DIM)) begin
      eff_h = SizeW'(rgb2yuv_pkg::MIN_DIM);
    end else if (SizeW'(height_q) > SizeW'(MaxDimension)) begin
      eff_h = SizeW'(MaxDimension);
    end
  end

  // A row or frame ends once the position reaches or passes the last one.
  assign last_col = (SizeW'(col_q) + SizeW'(1)) >= eff_w;
  assign last_row = (SizeW'(row_q) + SizeW'(1)) >= eff_h;

  always_comb begin
    col_d = col_q + CntW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_take_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Classify the pixel: Cb at even/even, Cr at odd/odd, frame end marker.
  always_comb begin
    pix_o.red          = red_i;
    pix_o.green        = green_i;
    pix_o.blue         = blue_i;
    pix_o.chroma_valid = (col_q[0] == row_q[0]);
    pix_o.chroma_is_cr = col_q[0] & row_q[0];
    pix_o.frame_end    = last_col & last_row;
  end

endmodule

// ===== hdl/rgb2yuv_queue.sv =====
// Short register queue that decouples the front end from the arithmetic pipeline.
// Depends on rgb2yuv_pkg for the pixel struct.

module rgb2yuv_queue #(
  parameter int Depth = rgb2yuv_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rgb2yuv_pkg::pix_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output rgb2yuv_pkg::pix_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rgb2yuv_pkg::pix_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/rgb2yuv_back.sv =====
// Back end: two-stage multiply-add pipeline that forms luma and chroma samples.
// Depends on rgb2yuv_pkg for coefficients, the pixel struct and scale_sample.

module rgb2yuv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  rgb2yuv_pkg::pix_t pix_i,
  output logic              pix_take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        luma_o,
  output logic              chroma_valid_o,
  output logic              chroma_is_cr_o,
  output logic [7:0]        chroma_o,
  output logic              frame_end_o
);

  rgb2yuv_pkg::sum_t r_s, g_s, b_s;
  rgb2yuv_pkg::sum_t cr_r, cr_g, cr_b;
  rgb2yuv_pkg::sum_t luma_sum_d, chroma_sum_d;
  rgb2yuv_pkg::sum_t luma_sum_q, chroma_sum_q;
  logic              s1_valid_q, s1_cvalid_q, s1_is_cr_q, s1_end_q;
  logic              s2_valid_q;
  logic              adv1, adv2;

  // Each stage moves when the one after it is empty or moving.
  assign adv2       = !s2_valid_q || !out_stall_i;
  assign adv1       = !s1_valid_q || adv2;
  assign pix_take_o = pix_valid_i && adv1;

  // Stage one: constant multiplies and sums; Cb or Cr coefficients by position.
  always_comb begin
    r_s  = rgb2yuv_pkg::sum_t'({1'b0, pix_i.red});
    g_s  = rgb2yuv_pkg::sum_t'({1'b0, pix_i.green});
    b_s  = rgb2yuv_pkg::sum_t'({1'b0, pix_i.blue});
    cr_r = pix_i.chroma_is_cr ? rgb2yuv_pkg::CR_R : rgb2yuv_pkg::CB_R;
    cr_g = pix_i.chroma_is_cr ? rgb2yuv_pkg::CR_G : rgb2yuv_pkg::CB_G;
    cr_b = pix_i.chroma_is_cr ? rgb2yuv_pkg::CR_B : rgb2yuv_pkg::CB_B;
    luma_sum_d   = r_s * rgb2yuv_pkg::Y_R + g_s * rgb2yuv_pkg::Y_G
                 + b_s * rgb2yuv_pkg::Y_B;
    chroma_sum_d = r_s * cr_r + g_s * cr_g + b_s * cr_b;
  end

  always_ff @(posedge clk_i) begin
    if (pix_take_o) begin
      luma_sum_q   <= luma_sum_d;
      chroma_sum_q <= chroma_sum_d;
      s1_cvalid_q  <= pix_i.chroma_valid;
      s1_is_cr_q   <= pix_i.chroma_is_cr;
      s1_end_q     <= pix_i.frame_end;
    end
  end

  // Stage two: round, shift, offset into the output register.
  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      luma_o         <= rgb2yuv_pkg::scale_sample(luma_sum_q, rgb2yuv_pkg::LUMA_OFFSET);
      chroma_valid_o <= s1_cvalid_q;
      chroma_is_cr_o <= s1_cvalid_q & s1_is_cr_q;
      chroma_o       <= s1_cvalid_q
                      ? rgb2yuv_pkg::scale_sample(chroma_sum_q, rgb2yuv_pkg::CHROMA_OFFSET)
                      : 8'd0;
      frame_end_o    <= s1_end_q;
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= pix_take_o;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = s2_valid_q;

endmodule

// ===== hdl/rgb24_to_yuv420_converter_top.sv =====
// Top level of the RGB to YCbCr 4:2:0 pixel stream converter.
// Depends on rgb2yuv_pkg, rgb2yuv_front, rgb2yuv_queue and rgb2yuv_back.
//
//   Channel  | Handshake              | Beat contents
//   ---------+------------------------+-----------------------------------------------
//   pixel in | in_valid_i / in_stall_o | red_i, green_i, blue_i
//   result   | out_valid_o / out_stall_i | luma_o, chroma_valid_o, chroma_is_cr_o,
//            |                        | chroma_o, frame_end_o
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel is taken per clock when nothing stalls; each result passes through the queue
// register, the multiply-add stage and the scaling stage.
// The two-entry queue between position tracking and the multiply-add pipeline sets the
// stall depth: in_stall_o rises only when the queue is full.
// Reset clears the row and column position and sets both frame sizes to 256.
// The config port is always ready; writes take effect on the next pixel.

module rgb24_to_yuv420_converter_top #(
  parameter int MaxDimension = rgb2yuv_pkg::MAX_DIM,
  parameter int QueueDepth   = rgb2yuv_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       red_i,
  input  logic [7:0]                       green_i,
  input  logic [7:0]                       blue_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       luma_o,
  output logic                             chroma_valid_o,
  output logic                             chroma_is_cr_o,
  output logic [7:0]                       chroma_o,
  output logic                             frame_end_o
);

  rgb2yuv_pkg::pix_t front_pix, queue_pix;
  logic              queue_full, queue_empty, pix_push, pix_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;
  assign pix_push    = in_valid_i && !queue_full;

  // Position tracking and classification.
  rgb2yuv_front #(
    .MaxDimension(MaxDimension)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pix_take_i (pix_push),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .pix_o      (front_pix)
  );

  // Decoupling queue.
  rgb2yuv_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (pix_push),
    .push_data_i(front_pix),
    .full_o     (queue_full),
    .pop_i      (pix_pop),
    .empty_o    (queue_empty),
    .pop_data_o (queue_pix)
  );

  // Arithmetic pipeline and output register.
  rgb2yuv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_valid_i   (!queue_empty),
    .pix_i         (queue_pix),
    .pix_take_o    (pix_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .luma_o        (luma_o),
    .chroma_valid_o(chroma_valid_o),
    .chroma_is_cr_o(chroma_is_cr_o),
    .chroma_o      (chroma_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// ===== hdl/rgb2yuv_checker.sv =====
// Port-level checker for the converter's result channel, bound to the top level.
// Depends only on the top level's ports.

module rgb2yuv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] luma_o,
  input logic       chroma_valid_o,
  input logic       chroma_is_cr_o,
  input logic [7:0] chroma_o,
  input logic       frame_end_o
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(luma_o) && $stable(chroma_o)
      && $stable(chroma_valid_o) && $stable(chroma_is_cr_o) && $stable(frame_end_o))
    else $error("stalled result beat changed");

  // Luma stays within studio range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> luma_o >= 8'd16 && luma_o <= 8'd235)
    else $error("luma outside studio range");

  // A present chroma sample stays within 16 to 240.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chroma_valid_o |-> chroma_o >= 8'd16 && chroma_o <= 8'd240)
    else $error("chroma outside studio range");

  // Without a chroma sample, the chroma fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |-> chroma_o == 8'd0 && !chroma_is_cr_o)
    else $error("chroma fields set without a chroma sample");

endmodule

bind rgb24_to_yuv420_converter_top rgb2yuv_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .luma_o        (luma_o),
  .chroma_valid_o(chroma_valid_o),
  .chroma_is_cr_o(chroma_is_cr_o),
  .chroma_o      (chroma_o),
  .frame_end_o   (frame_end_o)
);

// ===== verif/rgb24_to_yuv420_converter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the RGB to YCbCr 4:2:0 pixel stream converter.
// Depends on rgb2yuv_pkg and rgb24_to_yuv420_converter_top; predicts every beat on its own.

module rgb24_to_yuv420_converter_top_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int PRINT_CAP     = 40;

  // One result beat of the converter.
  typedef struct {
    logic [7:0] luma;
    logic       chroma_valid;
    logic       chroma_is_cr;
    logic [7:0] chroma;
    logic       frame_end;
  } yuv_beat_t;

  // Predicts the converter beat by beat and holds the beats still to come.
  class yuv_scoreboard;
    logic [rgb2yuv_pkg::CFG_W-1:0] width_reg;
    logic [rgb2yuv_pkg::CFG_W-1:0] height_reg;
    int unsigned                   col;
    int unsigned                   row;
    yuv_beat_t                     expected_q[$];

    function new();
      width_reg  = rgb2yuv_pkg::CFG_W'(256);
      height_reg = rgb2yuv_pkg::CFG_W'(256);
      col        = 0;
      row        = 0;
    endfunction

    // Sizes outside 2..MAX_DIM saturate into that range.
    function int unsigned clamp_size(logic [rgb2yuv_pkg::CFG_W-1:0] v);
      if (v < rgb2yuv_pkg::MIN_DIM) return rgb2yuv_pkg::MIN_DIM;
      if (v > rgb2yuv_pkg::MAX_DIM) return rgb2yuv_pkg::MAX_DIM;
      return v;
    endfunction

    // Round, floor-divide by 256, add the offset, keep eight bits.
    function logic [7:0] round_to_8bit(int sum, int offset);
      int q;
      q = ((sum + 128) >>> 8) + offset;
      return q[7:0];
    endfunction

    function void write_register(logic [rgb2yuv_pkg::CFG_IDX_W-1:0] idx,
                                 logic [rgb2yuv_pkg::CFG_W-1:0] val);
      if (idx == rgb2yuv_pkg::REG_FRAME_WIDTH) width_reg = val;
      else if (idx == rgb2yuv_pkg::REG_FRAME_HEIGHT) height_reg = val;
    endfunction

    // Work out the beat that an accepted pixel causes and advance the position.
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      yuv_beat_t   beat;
      int unsigned w;
      int unsigned h;
      bit          last_col;
      bit          last_row;
      int          ri;
      int          gi;
      int          bi;
      ri = r;
      gi = g;
      bi = b;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      beat.luma         = round_to_8bit(66 * ri + 129 * gi + 25 * bi, 16);
      beat.chroma_valid = 1'b0;
      beat.chroma_is_cr = 1'b0;
      beat.chroma       = 8'd0;
      if (!col[0] && !row[0]) begin
        beat.chroma_valid = 1'b1;
        beat.chroma       = round_to_8bit(-38 * ri - 74 * gi + 112 * bi, 128);
      end else if (col[0] && row[0]) begin
        beat.chroma_valid = 1'b1;
        beat.chroma_is_cr = 1'b1;
        beat.chroma       = round_to_8bit(112 * ri - 94 * gi - 18 * bi, 128);
      end
      beat.frame_end = last_col && last_row;
      expected_q.push_back(beat);
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    // Returns an empty string when the beat matches the oldest prediction.
    function string check_result(yuv_beat_t got);
      yuv_beat_t want;
      string     msg;
      if (expected_q.size() == 0)
        return $sformatf("result beat with no pixel pending, luma %0d", got.luma);
      want = expected_q.pop_front();
      msg = "";
      if (got.luma !== want.luma)
        msg = {msg, $sformatf(" luma %0d want %0d", got.luma, want.luma)};
      if (got.chroma_valid !== want.chroma_valid)
        msg = {msg, $sformatf(" chroma_valid %0b want %0b", got.chroma_valid, want.chroma_valid)};
      if (got.chroma_is_cr !== want.chroma_is_cr)
        msg = {msg, $sformatf(" chroma_is_cr %0b want %0b", got.chroma_is_cr, want.chroma_is_cr)};
      if (got.chroma !== want.chroma)
        msg = {msg, $sformatf(" chroma %0d want %0d", got.chroma, want.chroma)};
      if (got.frame_end !== want.frame_end)
        msg = {msg, $sformatf(" frame_end %0b want %0b", got.frame_end, want.frame_end)};
      return msg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              cfg_valid_i    = 1'b0;
  logic                              cfg_ready_o;
  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_data_i     = '0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic [7:0]                        red_i          = 8'd0;
  logic [7:0]                        green_i        = 8'd0;
  logic [7:0]                        blue_i         = 8'd0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic [7:0]                        luma_o;
  logic                              chroma_valid_o;
  logic                              chroma_is_cr_o;
  logic [7:0]                        chroma_o;
  logic                              frame_end_o;

  yuv_scoreboard sb = new();
  int unsigned   mismatch_count = 0;
  int unsigned   result_count   = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   stall_pct      = 0;
  logic          pressure_go    = 1'b0;
  logic          hold_off       = 1'b0;

  rgb24_to_yuv420_converter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .luma_o         (luma_o),
    .chroma_valid_o (chroma_valid_o),
    .chroma_is_cr_o (chroma_is_cr_o),
    .chroma_o       (chroma_o),
    .frame_end_o    (frame_end_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] beat %0d:%s", $realtime, result_count, msg);
    mismatch_count++;
  endtask

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register writes and pixel beats feed the predictor as they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.write_register(cfg_index_i, cfg_data_i);
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_pixel(red_i, green_i, blue_i);
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    yuv_beat_t got;
    string     msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.luma         = luma_o;
      got.chroma_valid = chroma_valid_o;
      got.chroma_is_cr = chroma_is_cr_o;
      got.chroma       = chroma_o;
      got.frame_end    = frame_end_o;
      msg = sb.check_result(got);
      if (msg != "") report_mismatch(msg);
      result_count++;
    end
  end

  // Receiver side: random stalls, plus the long hold-off when requested.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Long hold-off of the receiver so that the block fills up and stalls its input.
  initial begin
    @(posedge clk_i);
    while (!pressure_go) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Pixel components lean toward the extremes now and then.
  function automatic logic [7:0] random_component();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Offer one pixel beat and wait until it is taken; valid stays high afterwards.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic write_register(input logic [rgb2yuv_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rgb2yuv_pkg::CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Waits until the last accepted pixel is predicted, then until every predicted beat
  // has come out, then lets the pipeline drain.
  task automatic settle();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both sizes, then a write to an index past the register list that must be ignored.
  task automatic configure_sizes(input logic [rgb2yuv_pkg::CFG_W-1:0] w,
                                 input logic [rgb2yuv_pkg::CFG_W-1:0] h,
                                 input logic [rgb2yuv_pkg::CFG_IDX_W-1:0] stray_idx);
    settle();
    write_register(rgb2yuv_pkg::REG_FRAME_WIDTH, w);
    write_register(rgb2yuv_pkg::REG_FRAME_HEIGHT, h);
    write_register(stray_idx, rgb2yuv_pkg::CFG_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [rgb2yuv_pkg::CFG_W-1:0] w,
                           input logic [rgb2yuv_pkg::CFG_W-1:0] h,
                           input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_in_pct, input bit pressure);
    configure_sizes(w, h, rgb2yuv_pkg::CFG_IDX_W'(
                    $urandom_range(15, rgb2yuv_pkg::REG_FRAME_HEIGHT + 1)));
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    if (pressure) pressure_go <= 1'b1;
    repeat (count) send_pixel(random_component(), random_component(), random_component());
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [23:0] directed[16];
    directed = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                 24'h808080, 24'h7F7F7F, 24'h010203, 24'hFEFDFC,
                 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few pixels at the reset frame size.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    in_valid_i <= 1'b0;

    // Sizes 1 and 0 act as 2; the row ends at once since the column is already past.
    configure_sizes(rgb2yuv_pkg::CFG_W'(1), rgb2yuv_pkg::CFG_W'(0), '1);
    foreach (directed[i]) send_pixel(directed[i][23:16], directed[i][15:8], directed[i][7:0]);
    in_valid_i <= 1'b0;

    // Random phases under every idling pattern.
    run_phase(rgb2yuv_pkg::CFG_W'(3), rgb2yuv_pkg::CFG_W'(2), 120, 0, 0, 1'b0);
    run_phase(rgb2yuv_pkg::CFG_W'(5), rgb2yuv_pkg::CFG_W'(4), 180, 75, 0, 1'b0);
    run_phase(rgb2yuv_pkg::CFG_W'(2), rgb2yuv_pkg::CFG_W'(3), 180, 0, 75, 1'b0);
    run_phase(rgb2yuv_pkg::CFG_W'(7), rgb2yuv_pkg::CFG_W'(5), 180, 23, 23, 1'b0);

    // Largest sizes, saturation from above, then a shrink in the middle of a row.
    run_phase(rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MAX_DIM), '1, 40, 0, 0, 1'b0);
    run_phase('1, rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MAX_DIM + 1), 30, 23, 23, 1'b0);
    run_phase(rgb2yuv_pkg::CFG_W'(6), rgb2yuv_pkg::CFG_W'(3), 120, 0, 0, 1'b1);
    run_phase(rgb2yuv_pkg::CFG_W'(0), rgb2yuv_pkg::CFG_W'(1), 80, 23, 23, 1'b0);

    // Many rows deep, then the height shrinks below the current row.
    run_phase(rgb2yuv_pkg::CFG_W'(2), rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MAX_DIM), 20, 0, 0, 1'b0);
    run_phase(rgb2yuv_pkg::CFG_W'(3), rgb2yuv_pkg::CFG_W'(4), 100, 23, 23, 1'b0);

    settle();
    if (mismatch_count == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
